// ===== src/fan_duty_with_setpoint_buttons_assert.svh =====
// assertion macros shared by the checker
`ifndef FAN_DUTY_WITH_SETPOINT_BUTTONS_ASSERT_SVH
`define FAN_DUTY_WITH_SETPOINT_BUTTONS_ASSERT_SVH

// checked outside reset
`define FDSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FDSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/fdsb_pkg.sv =====
// types and constants of the fan duty controller
`default_nettype none

package fdsb_pkg;

  localparam int unsigned ADC_W      = 12;
  localparam int unsigned TEMP_W     = 7;
  localparam int unsigned SP_W       = 8;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned OFS_W      = 4;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam int unsigned MV_FULL    = 3000;
  localparam int unsigned MV_PER_DEG = 30;

  localparam logic [TEMP_W-1:0] TEMP_LIMIT = 7'd100;
  localparam logic [SP_W-1:0]   SP_MAX     = 8'd255;
  localparam logic [SP_W-1:0]   SP_MIN     = 8'd0;

  localparam logic [GAIN_W-1:0] GAIN_RST = 8'd50;
  localparam logic [DUTY_W-1:0] BASE_RST = 10'd200;
  localparam logic [DUTY_W-1:0] MAX_RST  = 10'd699;
  localparam logic [OFS_W-1:0]  OFS_RST  = 4'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_UP     = 2'd1,
    CMD_DOWN   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_BASE   = 2'd1,
    REG_MAX    = 2'd2,
    REG_OFFSET = 2'd3
  } reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [DUTY_W-1:0] base;
    logic [DUTY_W-1:0] dmax;
    logic [OFS_W-1:0]  offset;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [TEMP_W-1:0] temp;
  } item_t;

  // duty in the lowest bits
  typedef struct packed {
    logic              fan_on;
    logic [SP_W-1:0]   setpoint;
    logic [TEMP_W-1:0] temp;
    logic [DUTY_W-1:0] duty;
  } result_t;

endpackage

`default_nettype wire

// ===== src/fdsb_convert.sv =====
// adc reading to whole degrees by reciprocal multiply
`default_nettype none

module fdsb_convert #(
  parameter int unsigned ADC_FULL_SCALE = 4095
) (
  input  logic [fdsb_pkg::ADC_W-1:0]  adc_i,
  output logic [fdsb_pkg::TEMP_W-1:0] temp_o
);
  import fdsb_pkg::*;

  localparam int unsigned       FS_W   = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned       SHIFT  = ADC_W + FS_W;
  localparam longint unsigned   SCALE  = MV_FULL / MV_PER_DEG;
  localparam longint unsigned   RECIP  =
    ((SCALE << SHIFT) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE;
  localparam int unsigned       RW     = $clog2(RECIP + 1);
  localparam int unsigned       PW     = ADC_W + RW;
  localparam int unsigned       DW     = PW - SHIFT;
  localparam int unsigned       CW     = (DW > TEMP_W) ? DW : TEMP_W;

  logic [PW-1:0] prod;
  logic [CW-1:0] deg;

  // floor(raw * 100 / full scale), exact since raw * full scale < 2^shift
  assign prod   = PW'(adc_i) * PW'(RECIP);
  assign deg    = CW'(prod[PW-1:SHIFT]);
  assign temp_o = (deg > CW'(TEMP_LIMIT)) ? TEMP_LIMIT : deg[TEMP_W-1:0];

endmodule

`default_nettype wire

// ===== src/fdsb_core.sv =====
// controller state, setpoint buttons and duty law
`default_nettype none

module fdsb_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  fdsb_pkg::item_t   item_i,
  input  fdsb_pkg::cfg_t    cfg_i,
  output fdsb_pkg::result_t result_o
);
  import fdsb_pkg::*;

  logic [SP_W-1:0]   target_q, target_d;
  logic [DUTY_W-1:0] drive_q, drive_d;
  logic [TEMP_W-1:0] last_q, last_d;
  logic              started_q, started_d;
  logic              up_first_q, up_first_d, up_second_q, up_second_d;
  logic              dn_first_q, dn_first_d, dn_second_q, dn_second_d;
  logic              phase_q, phase_d;

  logic [SP_W:0]            sp_sum;
  logic [SP_W-1:0]          sp_init;
  logic [SP_W-1:0]          tgt_eff;
  logic [SP_W-1:0]          diff;
  logic [TEMP_W+GAIN_W-1:0] prod;
  logic [TEMP_W+GAIN_W:0]   sum;
  logic [DUTY_W-1:0]        drive_on;

  assign sp_sum   = (SP_W+1)'(item_i.temp) + (SP_W+1)'(cfg_i.offset);
  assign sp_init  = sp_sum[SP_W] ? SP_MAX : sp_sum[SP_W-1:0];
  assign tgt_eff  = started_q ? target_q : sp_init;
  assign diff     = SP_W'(item_i.temp) - tgt_eff;
  assign prod     = (TEMP_W+GAIN_W)'(diff[TEMP_W-1:0]) * (TEMP_W+GAIN_W)'(cfg_i.gain);
  assign sum      = (TEMP_W+GAIN_W+1)'(prod) + (TEMP_W+GAIN_W+1)'(cfg_i.base);
  assign drive_on = (sum > (TEMP_W+GAIN_W+1)'(cfg_i.dmax)) ? cfg_i.dmax
                                                            : sum[DUTY_W-1:0];

  always_comb begin
    target_d    = target_q;
    drive_d     = drive_q;
    last_d      = last_q;
    started_d   = started_q;
    up_first_d  = up_first_q;
    up_second_d = up_second_q;
    dn_first_d  = dn_first_q;
    dn_second_d = dn_second_q;
    phase_d     = phase_q;
    case (item_i.cmd)
      CMD_SAMPLE: begin
        last_d    = item_i.temp;
        target_d  = tgt_eff;
        started_d = 1'b1;
        if (SP_W'(item_i.temp) > tgt_eff) begin
          drive_d = drive_on;
        end else if (SP_W'(item_i.temp) < tgt_eff) begin
          drive_d = '0;
        end
      end
      CMD_UP: begin
        if (!up_first_q && !up_second_q) begin
          up_first_d  = 1'b1;
          up_second_d = 1'b1;
          if (target_q != SP_MAX) begin
            target_d = target_q + SP_W'(1);
          end
        end
      end
      CMD_DOWN: begin
        if (!dn_first_q && !dn_second_q) begin
          dn_first_d  = 1'b1;
          dn_second_d = 1'b1;
          if (target_q != SP_MIN) begin
            target_d = target_q - SP_W'(1);
          end
        end
      end
      CMD_TICK: begin
        if (!phase_q) begin
          up_first_d = 1'b0;
          dn_first_d = 1'b0;
        end else begin
          up_second_d = 1'b0;
          dn_second_d = 1'b0;
        end
        phase_d = !phase_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      drive_q     <= '0;
      last_q      <= '0;
      started_q   <= 1'b0;
      up_first_q  <= 1'b0;
      up_second_q <= 1'b0;
      dn_first_q  <= 1'b0;
      dn_second_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (step_i) begin
      target_q    <= target_d;
      drive_q     <= drive_d;
      last_q      <= last_d;
      started_q   <= started_d;
      up_first_q  <= up_first_d;
      up_second_q <= up_second_d;
      dn_first_q  <= dn_first_d;
      dn_second_q <= dn_second_d;
      phase_q     <= phase_d;
    end
  end

  assign result_o.duty     = drive_d;
  assign result_o.temp     = last_d;
  assign result_o.setpoint = target_d;
  assign result_o.fan_on   = (drive_d != '0);

endmodule

`default_nettype wire

// ===== src/fan_duty_with_setpoint_buttons.sv =====
// fan duty controller top level: config registers and word pipeline
// a word accepted into the input register moves through the duty law into the output register
// throughput: one word per cycle, limited only by the output handshake
// the adc conversion multiply sits before the input register, the duty law after it
// reset clears all controller state and the pipeline valid flags, config returns to defaults
`default_nettype none

module fan_duty_with_setpoint_buttons #(
  parameter int unsigned ADC_FULL_SCALE = 4095
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fdsb_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [fdsb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [fdsb_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // adc_sample, zero pad
  input  logic [fdsb_pkg::CMD_W-1:0]      s_axis_tuser,  // cmd
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fdsb_pkg::M_TDATA_W-1:0]  m_axis_tdata   // duty, temperature, setpoint,
                                                         // fan_on, zero pad
);
  import fdsb_pkg::*;

  cfg_t              cfg_q;
  logic              in_valid_q;
  item_t             in_item_q, in_item_d;
  logic              out_valid_q;
  result_t           out_q, result;
  logic              advance, accept;
  logic [TEMP_W-1:0] conv_temp;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  fdsb_convert #(
    .ADC_FULL_SCALE(ADC_FULL_SCALE)
  ) u_convert (
    .adc_i (s_axis_tdata[ADC_W-1:0]),
    .temp_o(conv_temp)
  );

  assign in_item_d.cmd  = cmd_e'(s_axis_tuser);
  assign in_item_d.temp = conv_temp;

  fdsb_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_item_q),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain   <= GAIN_RST;
      cfg_q.base   <= BASE_RST;
      cfg_q.dmax   <= MAX_RST;
      cfg_q.offset <= OFS_RST;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_GAIN:   cfg_q.gain   <= cfg_wdata_i[GAIN_W-1:0];
        REG_BASE:   cfg_q.base   <= cfg_wdata_i[DUTY_W-1:0];
        REG_MAX:    cfg_q.dmax   <= cfg_wdata_i[DUTY_W-1:0];
        REG_OFFSET: cfg_q.offset <= cfg_wdata_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_q);

endmodule

`default_nettype wire

// ===== src/fdsb_checker.sv =====
// port checker for the fan duty controller and its bind
`default_nettype none

`include "fan_duty_with_setpoint_buttons_assert.svh"

module fdsb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fdsb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import fdsb_pkg::*;

  result_t                               res;
  logic [M_TDATA_W-$bits(result_t)-1:0] pad;
  logic                                  stall;

  assign res   = m_axis_tdata[$bits(result_t)-1:0];
  assign pad   = m_axis_tdata[M_TDATA_W-1:$bits(result_t)];
  assign stall = m_axis_tvalid && !m_axis_tready;

  `FDSB_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |=> !m_axis_tvalid, "word during reset")

  `FDSB_ASSERT(a_out_hold, stall |=> m_axis_tvalid && $stable(m_axis_tdata), "word changed")

  `FDSB_ASSERT(a_fan_on_match, m_axis_tvalid |-> (res.fan_on == (res.duty != '0)), "fan_on wrong")

  `FDSB_ASSERT(a_temp_limit, m_axis_tvalid |-> (res.temp <= TEMP_LIMIT), "temperature too high")

  `FDSB_ASSERT(a_pad_zero, m_axis_tvalid |-> (pad == '0), "result padding not zero")

endmodule

bind fan_duty_with_setpoint_buttons fdsb_checker u_fdsb_checker (.*);

`default_nettype wire

// ===== bench/fan_duty_with_setpoint_buttons_test.sv =====
// self-checking bench for the fan duty controller: random and directed words vs. a local model
module fan_duty_with_setpoint_buttons_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fdsb_pkg::*;

  localparam int unsigned ADC_FS          = 4095;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    cmd_e             cmd;
    logic [ADC_W-1:0] raw;
  } fan_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // adc_sample, zero pad
  logic [CMD_W-1:0]      s_axis_tuser;   // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // duty, temperature, setpoint, fan_on, zero pad

  fan_word_t pending_words_q[$];
  result_t   expected_status_q[$];
  fan_word_t next_word;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_reqs;
  int unsigned hold_done;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  logic        word_sent;

  // controller model state
  cfg_t              cfg_now;
  logic [SP_W-1:0]   sp_now;
  logic [DUTY_W-1:0] duty_now;
  logic [TEMP_W-1:0] temp_now;
  logic              seeded;
  logic              up_lock_a;
  logic              up_lock_b;
  logic              dn_lock_a;
  logic              dn_lock_b;
  logic              tick_odd;

  fan_duty_with_setpoint_buttons #(
    .ADC_FULL_SCALE(ADC_FS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic result_t advance_fan_model(fan_word_t w);
    int unsigned mv;
    int unsigned deg;
    int unsigned sp;
    int unsigned d;
    result_t     r;
    case (w.cmd)
      CMD_SAMPLE: begin
        mv  = int'(w.raw) * MV_FULL / ADC_FS;
        deg = mv / MV_PER_DEG;
        if (deg > TEMP_LIMIT) deg = 32'(TEMP_LIMIT);
        temp_now = deg[TEMP_W-1:0];
        if (!seeded) begin
          sp = deg + cfg_now.offset;
          sp_now = (sp > SP_MAX) ? SP_MAX : sp[SP_W-1:0];
          seeded = 1'b1;
        end
        if (deg > sp_now) begin
          d = (deg - sp_now) * cfg_now.gain + cfg_now.base;
          duty_now = (d > cfg_now.dmax) ? cfg_now.dmax : d[DUTY_W-1:0];
        end else if (deg < sp_now) begin
          duty_now = '0;
        end
      end
      CMD_UP: begin
        if (!up_lock_a && !up_lock_b) begin
          up_lock_a = 1'b1;
          up_lock_b = 1'b1;
          if (sp_now != SP_MAX) sp_now = sp_now + 1'b1;
        end
      end
      CMD_DOWN: begin
        if (!dn_lock_a && !dn_lock_b) begin
          dn_lock_a = 1'b1;
          dn_lock_b = 1'b1;
          if (sp_now != SP_MIN) sp_now = sp_now - 1'b1;
        end
      end
      default: begin
        if (!tick_odd) begin
          up_lock_a = 1'b0;
          dn_lock_a = 1'b0;
        end else begin
          up_lock_b = 1'b0;
          dn_lock_b = 1'b0;
        end
        tick_odd = !tick_odd;
      end
    endcase
    r.duty     = duty_now;
    r.temp     = temp_now;
    r.setpoint = sp_now;
    r.fan_on   = (duty_now != '0);
    return r;
  endfunction

  // input side
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !word_sent)) begin
      if (pending_words_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_word = pending_words_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-ADC_W){1'b0}}, next_word.raw};
        s_axis_tuser  <= next_word.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side, with long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_done != hold_reqs) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= hold_done + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    word_sent <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_status_q.push_back(advance_fan_model(fan_word_t'{
          cmd_e'(s_axis_tuser), s_axis_tdata[ADC_W-1:0]}));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (expected_status_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("unexpected word: duty %0d temp %0d setpoint %0d fan_on %0d",
                     got.duty, got.temp, got.setpoint, got.fan_on);
        end else begin
          want = expected_status_q.pop_front();
          if (got.duty != want.duty || got.temp != want.temp ||
              got.setpoint != want.setpoint || got.fan_on != want.fan_on) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_REPORTS) begin
              $display("mismatch at %0t: exp duty %0d temp %0d setpoint %0d fan_on %0d",
                       $realtime, want.duty, want.temp, want.setpoint, want.fan_on);
              $display("  got duty %0d temp %0d setpoint %0d fan_on %0d",
                       got.duty, got.temp, got.setpoint, got.fan_on);
            end
          end
        end
      end
    end
  end

  // watchdog: stalled while work is outstanding
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (pending_words_q.size() != 0 || s_axis_tvalid ||
                 expected_status_q.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_word(cmd_e c, logic [ADC_W-1:0] raw);
    pending_words_q.push_back(fan_word_t'{c, raw});
  endtask

  task automatic push_other(cmd_e c);
    push_word(c, ADC_W'($urandom_range(4095)));
  endtask

  task automatic step_setpoint(cmd_e dir, int unsigned steps);
    repeat (steps) begin
      push_other(dir);
      push_other(CMD_TICK);
      push_other(CMD_TICK);
    end
  endtask

  task automatic add_traffic(int unsigned n);
    int unsigned start;
    int unsigned pick;
    cmd_e        dir;
    start = pending_words_q.size();
    while (pending_words_q.size() - start < n) begin
      pick = $urandom_range(99);
      dir  = $urandom_range(1) ? CMD_UP : CMD_DOWN;
      if (pick < 40) push_word(CMD_SAMPLE, ADC_W'($urandom_range(4095)));
      else if (pick < 70) step_setpoint(dir, 1);
      else if (pick < 80) push_other(dir);
      else if (pick < 90) push_other(CMD_TICK);
      else step_setpoint(dir, $urandom_range(1, 15));
    end
  endtask

  task automatic set_reg(reg_e idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    case (idx)
      REG_GAIN: cfg_now.gain   = v[GAIN_W-1:0];
      REG_BASE: cfg_now.base   = v[DUTY_W-1:0];
      REG_MAX:  cfg_now.dmax   = v[DUTY_W-1:0];
      default:  cfg_now.offset = v[OFS_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    word_sent     = 1'b0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    hold_reqs     = 0;
    hold_done     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    mismatches    = 0;
    cfg_now       = cfg_t'{GAIN_RST, BASE_RST, MAX_RST, OFS_RST};
    sp_now        = '0;
    duty_now      = '0;
    temp_now      = '0;
    seeded        = 1'b0;
    up_lock_a     = 1'b0;
    up_lock_b     = 1'b0;
    dn_lock_a     = 1'b0;
    dn_lock_b     = 1'b0;
    tick_odd      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_reg(REG_OFFSET, 10'd15);

    tx_idle_pct = 31;
    rx_idle_pct = 62;

    // buttons before the first sample, lockout and the lower limit
    push_other(CMD_DOWN);
    push_other(CMD_UP);
    push_other(CMD_TICK);
    push_other(CMD_TICK);
    push_other(CMD_UP);
    push_other(CMD_UP);
    push_other(CMD_TICK);
    push_other(CMD_UP);
    push_other(CMD_TICK);
    push_other(CMD_UP);
    push_other(CMD_TICK);
    push_other(CMD_TICK);
    push_other(CMD_DOWN);
    // first sample seeds the setpoint, then saturation, hold and off
    push_word(CMD_SAMPLE, 12'h000);
    push_word(CMD_SAMPLE, 12'hFFF);
    push_word(CMD_SAMPLE, 12'd614);
    push_word(CMD_SAMPLE, 12'd655);
    push_word(CMD_SAMPLE, 12'hAAA);
    push_word(CMD_SAMPLE, 12'h555);
    push_word(CMD_SAMPLE, 12'd100);
    push_word(CMD_TICK, 12'hFFF);
    push_word(CMD_UP, 12'h000);
    push_word(CMD_SAMPLE, 12'h001);
    drain();

    set_reg(REG_GAIN, 10'd255);
    set_reg(REG_BASE, 10'd1023);
    set_reg(REG_MAX, 10'd1023);
    add_traffic(200);
    drain();

    tx_idle_pct = 62;
    rx_idle_pct = 31;
    set_reg(REG_GAIN, 10'd0);
    set_reg(REG_BASE, 10'd0);
    set_reg(REG_MAX, 10'd0);
    set_reg(REG_OFFSET, 10'd0);
    add_traffic(200);
    drain();

    // base above max, setpoint driven to both limits, long output stall
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_reg(REG_GAIN, 10'($urandom_range(1, 20)));
    set_reg(REG_BASE, 10'd900);
    set_reg(REG_MAX, 10'd300);
    add_traffic(50);
    step_setpoint(CMD_UP, 256);
    push_word(CMD_SAMPLE, 12'hFFF);
    push_word(CMD_SAMPLE, ADC_W'($urandom_range(4095)));
    step_setpoint(CMD_DOWN, 256);
    push_word(CMD_SAMPLE, 12'h000);
    push_word(CMD_SAMPLE, ADC_W'($urandom_range(4095)));
    add_traffic(50);
    hold_reqs = hold_reqs + 1;
    drain();

    set_reg(REG_GAIN, 10'(GAIN_RST));
    set_reg(REG_BASE, 10'(BASE_RST));
    set_reg(REG_MAX, 10'(MAX_RST));
    set_reg(REG_OFFSET, 10'(OFS_RST));
    add_traffic(80);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
